/* src/frc_pkg.sv */
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types, constants and the crc helper of the frame receiver.
// ----------------------------------------------------------------------------
package frc_pkg;

	localparam int BUF_DEPTH_DEF = 64;
	localparam int CNT_W         = 7;

	// configuration register indexes
	localparam logic [1:0] CFG_SYNC_FIRST      = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND     = 2'd1;
	localparam logic [1:0] CFG_MAX_PAYLOAD     = 2'd2;
	localparam logic [1:0] CFG_REJECT_OVERSIZE = 2'd3;

	localparam logic [7:0] SYNC_FIRST_RST      = 8'd170;
	localparam logic [7:0] SYNC_SECOND_RST     = 8'd85;
	localparam logic [6:0] MAX_PAYLOAD_RST     = 7'd64;
	localparam logic       REJECT_OVERSIZE_RST = 1'b1;

	// result event codes
	localparam logic [1:0] EV_GOOD    = 2'd0;
	localparam logic [1:0] EV_BAD_CRC = 2'd1;
	localparam logic [1:0] EV_BAD_LEN = 2'd2;
	localparam logic [1:0] EV_DROP    = 2'd3;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	typedef enum logic [2:0] {
		IK_DROP,
		IK_BAD_LEN,
		IK_BAD_CRC,
		IK_GOOD_EMPTY,
		IK_GOOD_DATA
	} item_kind_t;

	typedef enum logic [8:0] {
		ST_SYNC1   = 9'b000000001,
		ST_SYNC2   = 9'b000000010,
		ST_TYPE    = 9'b000000100,
		ST_LEN     = 9'b000001000,
		ST_PAYLOAD = 9'b000010000,
		ST_CRC_LO  = 9'b000100000,
		ST_CRC_HI  = 9'b001000000,
		ST_EMIT_RD = 9'b010000000,
		ST_EMIT_WR = 9'b100000000
	} state_t;

	typedef struct packed {
		logic       ld_type;
		logic       ld_len;
		logic       ld_payload;
		logic       ld_crc_lo;
		logic       emit_init;
		logic       mem_rd;
		logic       emit_adv;
		logic       out_load;
		item_kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic sync1_hit;
		logic sync2_hit;
		logic oversize;
		logic len_zero;
		logic payload_done;
		logic crc_ok;
		logic cnt_zero;
		logic emit_last;
	} status_t;

	// crc-16/ccitt-false, one byte, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* src/frc_ctrl.sv */
// ----------------------------------------------------------------------------
// frc_ctrl
// Parser and delivery state machine; drives datapath commands from status.
// ----------------------------------------------------------------------------
module frc_ctrl import frc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   parsing;
	logic   take;

	assign parsing = (state_q != ST_EMIT_RD) && (state_q != ST_EMIT_WR);
	assign in_ready = parsing && st.out_free;
	assign take = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		cmd.out_kind = IK_DROP;
		state_nxt = state_q;
		case (state_q)
			ST_SYNC1: begin
				if (take) begin
					if (st.sync1_hit) begin
						state_nxt = ST_SYNC2;
					end else begin
						cmd.out_load = 1'b1;
						cmd.out_kind = IK_DROP;
					end
				end
			end
			ST_SYNC2: begin
				if (take) begin
					if (st.sync2_hit) begin
						state_nxt = ST_TYPE;
					end else begin
						cmd.out_load = 1'b1;
						cmd.out_kind = IK_DROP;
						state_nxt    = ST_SYNC1;
					end
				end
			end
			ST_TYPE: begin
				if (take) begin
					cmd.ld_type = 1'b1;
					state_nxt   = ST_LEN;
				end
			end
			ST_LEN: begin
				if (take) begin
					cmd.ld_len = 1'b1;
					if (st.oversize) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = IK_BAD_LEN;
						state_nxt    = ST_SYNC1;
					end else if (st.len_zero) begin
						state_nxt = ST_CRC_LO;
					end else begin
						state_nxt = ST_PAYLOAD;
					end
				end
			end
			ST_PAYLOAD: begin
				if (take) begin
					cmd.ld_payload = 1'b1;
					if (st.payload_done) begin
						state_nxt = ST_CRC_LO;
					end
				end
			end
			ST_CRC_LO: begin
				if (take) begin
					cmd.ld_crc_lo = 1'b1;
					state_nxt     = ST_CRC_HI;
				end
			end
			ST_CRC_HI: begin
				if (take) begin
					if (!st.crc_ok) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = IK_BAD_CRC;
						state_nxt    = ST_SYNC1;
					end else if (st.cnt_zero) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = IK_GOOD_EMPTY;
						state_nxt    = ST_SYNC1;
					end else begin
						cmd.emit_init = 1'b1;
						state_nxt     = ST_EMIT_RD;
					end
				end
			end
			ST_EMIT_RD: begin
				cmd.mem_rd = 1'b1;
				state_nxt  = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = IK_GOOD_DATA;
					cmd.emit_adv = 1'b1;
					state_nxt    = st.emit_last ? ST_SYNC1 : ST_EMIT_RD;
				end
			end
			default: begin
				state_nxt = ST_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SYNC1;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* src/frc_dp.sv */
// ----------------------------------------------------------------------------
// frc_dp
// Config registers, header and crc registers, payload store and result register.
// ----------------------------------------------------------------------------
module frc_dp import frc_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [7:0] frame_type,
	output logic [7:0] frame_length,
	output logic       has_data,
	output logic [7:0] data_byte,
	output logic [5:0] byte_index,
	output logic       last,
	input  cmd_t       cmd,
	output status_t    st
);

	localparam int IDXW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);

	logic [7:0]       sync_first_q;
	logic [7:0]       sync_second_q;
	logic [6:0]       max_payload_q;
	logic             reject_q;

	logic [7:0]       held_type_q;
	logic [7:0]       held_len_q;
	logic [7:0]       byte_count_q;
	logic [7:0]       crc_lo_q;
	logic [15:0]      crc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] emit_idx_q;
	logic [7:0]       rdata_q;
	logic [7:0]       mem [BUF_DEPTH];

	logic             out_valid_q;
	logic [1:0]       ev_q;
	logic [7:0]       type_q;
	logic [7:0]       len_q;
	logic             has_q;
	logic [7:0]       data_q;
	logic [5:0]       idx_q;
	logic             last_q;

	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] cnt;
	logic             store_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
			reject_q      <= REJECT_OVERSIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SYNC_FIRST:      sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND:     sync_second_q <= cfg_data;
				CFG_MAX_PAYLOAD:     max_payload_q <= cfg_data[6:0];
				CFG_REJECT_OVERSIZE: reject_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// capacity is max_payload saturated to the store depth
	assign cap = (max_payload_q > DEPTH_C) ? DEPTH_C : max_payload_q;
	assign cnt = (held_len_q > {1'b0, cap}) ? cap : held_len_q[CNT_W-1:0];
	assign store_ok = byte_count_q < {1'b0, cap};

	always_comb begin
		st.out_free     = !out_valid_q || out_ready;
		st.sync1_hit    = rx_byte == sync_first_q;
		st.sync2_hit    = rx_byte == sync_second_q;
		st.oversize     = reject_q && (rx_byte > {1'b0, cap});
		st.len_zero     = rx_byte == 8'd0;
		st.payload_done = (byte_count_q + 8'd1) >= held_len_q;
		st.crc_ok       = {rx_byte, crc_lo_q} == crc_q;
		st.cnt_zero     = cnt == '0;
		st.emit_last    = (emit_idx_q + CNT_W'(1)) == cnt_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_type) begin
			held_type_q <= rx_byte;
			crc_q       <= crc16_byte(CRC_INIT, rx_byte);
		end
		if (cmd.ld_len) begin
			held_len_q   <= rx_byte;
			byte_count_q <= 8'd0;
			crc_q        <= crc16_byte(crc_q, rx_byte);
		end
		if (cmd.ld_payload) begin
			byte_count_q <= byte_count_q + 8'd1;
			crc_q        <= crc16_byte(crc_q, rx_byte);
		end
		if (cmd.ld_crc_lo) begin
			crc_lo_q <= rx_byte;
		end
		if (cmd.emit_init) begin
			cnt_q      <= cnt;
			emit_idx_q <= '0;
		end else if (cmd.emit_adv) begin
			emit_idx_q <= emit_idx_q + CNT_W'(1);
		end
	end

	// payload store, registered read
	always_ff @(posedge clk) begin
		if (cmd.ld_payload && store_ok) begin
			mem[byte_count_q[IDXW-1:0]] <= rx_byte;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[emit_idx_q[IDXW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			has_q  <= 1'b0;
			data_q <= 8'd0;
			idx_q  <= 6'd0;
			last_q <= 1'b1;
			type_q <= held_type_q;
			len_q  <= held_len_q;
			case (cmd.out_kind)
				IK_DROP: begin
					ev_q   <= EV_DROP;
					type_q <= 8'd0;
					len_q  <= 8'd0;
				end
				IK_BAD_LEN: begin
					ev_q  <= EV_BAD_LEN;
					len_q <= rx_byte;
				end
				IK_BAD_CRC: begin
					ev_q <= EV_BAD_CRC;
				end
				IK_GOOD_EMPTY: begin
					ev_q <= EV_GOOD;
				end
				IK_GOOD_DATA: begin
					ev_q   <= EV_GOOD;
					has_q  <= 1'b1;
					data_q <= rdata_q;
					idx_q  <= emit_idx_q[5:0];
					last_q <= st.emit_last;
				end
				default: begin
					ev_q <= EV_DROP;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = ev_q;
	assign frame_type   = type_q;
	assign frame_length = len_q;
	assign has_data     = has_q;
	assign data_byte    = data_q;
	assign byte_index   = idx_q;
	assign last         = last_q;

endmodule

/* src/frame_receiver_crc16_check.sv */
// ----------------------------------------------------------------------------
// frame_receiver_crc16_check
// Sync/length framed byte receiver with crc-16/ccitt-false check.
//
// channel   signals                                        direction
// cfg       cfg_valid cfg_ready cfg_index cfg_data          write in
// in        in_valid in_ready rx_byte                       byte in
// out       out_valid out_ready event_res frame_type        result out
//           frame_length has_data data_byte byte_index last
//
// each received byte is handled by the parser state machine.
// a good frame with n stored bytes then delivers them one at a time, each by a
// store read and then a result register load; no byte is taken during delivery.
// every byte transfer needs a free result register, so a result waiting for
// transfer stalls the input.
// reset puts the parser on hunting for the first sync byte and loads config
// defaults; the payload store is not cleared.
// ----------------------------------------------------------------------------
module frame_receiver_crc16_check import frc_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [7:0] frame_type,
	output logic [7:0] frame_length,
	output logic       has_data,
	output logic [7:0] data_byte,
	output logic [5:0] byte_index,
	output logic       last
);

	cmd_t    cmd;
	status_t st;

	frc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	frc_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.has_data     (has_data),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.last         (last),
		.cmd          (cmd),
		.st           (st)
	);

	// a result is never written over one still waiting for transfer
	assert property (@(posedge clk) disable iff (!arst_n) cmd.out_load |-> st.out_free)
		else $error("result register overwritten");

	// no input transfer while the store is being read out
	assert property (@(posedge clk) disable iff (!arst_n) cmd.mem_rd |-> !in_ready)
		else $error("input taken during delivery");

	// delivery starts with a store read right after the good crc
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit_init |=> cmd.mem_rd)
		else $error("delivery did not start");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the sync/length framed byte receiver with crc-16 check.
// Bytes go in over a valid/ready link with random gaps. Results come out
// under random back-pressure. A behavioral model of the parser runs on each
// byte transfer and queues the results the block must deliver. Each result
// transfer is compared field by field against the oldest queued result.
// Directed frames come first, then random framed traffic in several idling
// phases with different sync, capacity and oversize settings.
// ----------------------------------------------------------------------------
module tb import frc_pkg::*; ();

	localparam int CLK_HALF    = 6;
	localparam int RST_CYCLES  = 11;
	localparam int SETTLE      = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] ftype;
		logic [7:0] flen;
		logic       has;
		logic [7:0] data;
		logic [5:0] idx;
		logic       last;
	} rx_item_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] event_res;
	logic [7:0] frame_type;
	logic [7:0] frame_length;
	logic       has_data;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic       last;

	// parser model state and its copy of the registers
	state_t      parse_st;
	logic [7:0]  hdr_type;
	logic [7:0]  hdr_len;
	logic [7:0]  pay_count;
	logic [15:0] crc_rx;
	logic [15:0] crc_calc;
	logic [7:0]  pay_store [BUF_DEPTH_DEF];
	logic [7:0]  sync1_val;
	logic [7:0]  sync2_val;
	logic [6:0]  max_pay;
	logic        rej_over;

	rx_item_t    expected_items [$];
	logic [7:0]  link_fifo [$];
	int          bytes_queued  = 0;
	int          snd_idle_pct  = 0;
	int          rcv_stall_pct = 0;
	int          n_errors      = 0;
	int unsigned cycle_cnt     = 0;

	frame_receiver_crc16_check DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.frame_type   (frame_type),
		.frame_length (frame_length),
		.has_data     (has_data),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------------
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic int store_cap();
		return (max_pay > BUF_DEPTH_DEF) ? BUF_DEPTH_DEF : int'(max_pay);
	endfunction

	function automatic void restart_hunt();
		parse_st  = ST_SYNC1;
		hdr_type  = 8'h00;
		hdr_len   = 8'h00;
		pay_count = 8'h00;
		crc_rx    = 16'h0000;
		crc_calc  = 16'h0000;
	endfunction

	function automatic void expect_item(input logic [1:0] ev, input logic [7:0] ty,
			input logic [7:0] len, input logic has, input logic [7:0] data,
			input logic [5:0] idx, input logic lst);
		rx_item_t it;
		it = '{ev, ty, len, has, data, idx, lst};
		expected_items.push_back(it);
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		int cap;
		int cnt;
		cap = store_cap();
		case (parse_st)
			ST_SYNC1: begin
				if (b == sync1_val) begin
					parse_st = ST_SYNC2;
				end else begin
					expect_item(EV_DROP, 8'h00, 8'h00, 1'b0, 8'h00, 6'd0, 1'b1);
				end
			end
			ST_SYNC2: begin
				if (b == sync2_val) begin
					parse_st = ST_TYPE;
				end else begin
					// dropped byte is not retried as a first sync
					expect_item(EV_DROP, 8'h00, 8'h00, 1'b0, 8'h00, 6'd0, 1'b1);
					restart_hunt();
				end
			end
			ST_TYPE: begin
				hdr_type = b;
				crc_calc = crc_step(CRC_INIT, b);
				parse_st = ST_LEN;
			end
			ST_LEN: begin
				hdr_len  = b;
				crc_calc = crc_step(crc_calc, b);
				if (rej_over && int'(b) > cap) begin
					expect_item(EV_BAD_LEN, hdr_type, hdr_len, 1'b0, 8'h00, 6'd0, 1'b1);
					restart_hunt();
				end else begin
					pay_count = 8'h00;
					parse_st  = (b == 8'h00) ? ST_CRC_LO : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				if (int'(pay_count) < cap) begin
					pay_store[pay_count] = b;
				end
				crc_calc  = crc_step(crc_calc, b);
				pay_count = pay_count + 8'd1;
				if (pay_count >= hdr_len) begin
					parse_st = ST_CRC_LO;
				end
			end
			ST_CRC_LO: begin
				crc_rx   = {8'h00, b};
				parse_st = ST_CRC_HI;
			end
			ST_CRC_HI: begin
				crc_rx[15:8] = b;
				if (crc_rx == crc_calc) begin
					// delivery uses the capacity in force now
					cnt = (int'(hdr_len) < cap) ? int'(hdr_len) : cap;
					if (cnt == 0) begin
						expect_item(EV_GOOD, hdr_type, hdr_len, 1'b0, 8'h00, 6'd0, 1'b1);
					end else begin
						for (int i = 0; i < cnt; i++) begin
							expect_item(EV_GOOD, hdr_type, hdr_len, 1'b1, pay_store[i],
								6'(i), (i == cnt - 1));
						end
					end
				end else begin
					expect_item(EV_BAD_CRC, hdr_type, hdr_len, 1'b0, 8'h00, 6'd0, 1'b1);
				end
				restart_hunt();
			end
			default: begin
				restart_hunt();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// link driver, result checker, watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_byte(link_fifo.pop_front());
		end
		// a pending transfer keeps valid and payload as they are
		if (!in_valid || in_ready) begin
			if (link_fifo.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte  <= link_fifo[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		rx_item_t want;
		if (out_valid && out_ready) begin
			if (expected_items.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual ev %0h type %0h len %0h",
					$time, event_res, frame_type, frame_length);
				n_errors++;
			end else begin
				want = expected_items.pop_front();
				check_field("event_res", want.ev, event_res);
				check_field("frame_type", want.ftype, frame_type);
				check_field("frame_length", want.flen, frame_length);
				check_field("has_data", want.has, has_data);
				check_field("data_byte", want.data, data_byte);
				check_field("byte_index", want.idx, byte_index);
				check_field("last", want.last, last);
			end
		end
		out_ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		link_fifo.push_back(b);
		bytes_queued++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (link_fifo.size() != 0 || in_valid || expected_items.size() != 0);
		// bytes that raise no result may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic back_to_hunt();
		wait_idle();
		while (parse_st != ST_SYNC1) begin
			if (parse_st == ST_PAYLOAD) begin
				repeat (int'(hdr_len) - int'(pay_count)) send_byte(8'($urandom_range(255)));
			end else if (parse_st == ST_SYNC2) begin
				send_byte(~sync2_val);
			end else begin
				send_byte(8'($urandom_range(255)));
			end
			wait_idle();
		end
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SYNC_FIRST:      sync1_val = data;
			CFG_SYNC_SECOND:     sync2_val = data;
			CFG_MAX_PAYLOAD:     max_pay   = data[6:0];
			CFG_REJECT_OVERSIZE: rej_over  = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
			input logic [7:0] mp, input logic [7:0] rj);
		cfg_write(CFG_SYNC_FIRST, s1);
		cfg_write(CFG_SYNC_SECOND, s2);
		cfg_write(CFG_MAX_PAYLOAD, mp);
		cfg_write(CFG_REJECT_OVERSIZE, rj);
	endtask

	// keep < 0 sends the whole frame, else only its first keep bytes
	task automatic send_frame(input logic [7:0] ftype, input logic [7:0] pl [$],
			input bit bad_crc, input int keep);
		logic [7:0]  frm [$];
		logic [15:0] crc;
		crc = crc_step(CRC_INIT, ftype);
		crc = crc_step(crc, 8'(pl.size()));
		frm.push_back(sync1_val);
		frm.push_back(sync2_val);
		frm.push_back(ftype);
		frm.push_back(8'(pl.size()));
		foreach (pl[k]) begin
			frm.push_back(pl[k]);
			crc = crc_step(crc, pl[k]);
		end
		if (bad_crc) begin
			crc = crc ^ (16'h0001 << $urandom_range(15));
		end
		frm.push_back(crc[7:0]);
		frm.push_back(crc[15:8]);
		foreach (frm[k]) begin
			if (keep < 0 || k < keep) begin
				send_byte(frm[k]);
			end
		end
	endtask

	function automatic int pick_length();
		int r;
		int cap;
		r   = $urandom_range(99);
		cap = store_cap();
		if (r < 65) begin
			return $urandom_range(6);
		end
		if (r < 85) begin
			if (cap > 20) begin
				return $urandom_range(6);
			end
			return cap + int'($urandom_range(2)) - ((cap > 0) ? 1 : 0);
		end
		if (r < 90) begin
			return BUF_DEPTH_DEF;
		end
		return rej_over ? 255 : int'($urandom_range(6));
	endfunction

	task automatic random_traffic(input int n_bytes);
		int         start;
		int         r;
		int         len;
		int         keep;
		logic [7:0] pl [$];
		start = bytes_queued;
		while (bytes_queued - start < n_bytes) begin
			r = $urandom_range(99);
			if (r < 70) begin
				len = pick_length();
				pl.delete();
				repeat (len) pl.push_back(8'($urandom_range(255)));
				// a rejected header leaves the rest as dropped bytes
				keep = (rej_over && len > store_cap()) ? 4 + int'($urandom_range(3)) : -1;
				send_frame(8'($urandom_range(255)), pl, ($urandom_range(99) < 15), keep);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 3)) begin
					send_byte(($urandom_range(3) == 0) ? sync1_val : 8'($urandom_range(255)));
				end
			end else if (r < 93) begin
				send_byte(sync1_val);
				send_byte(~sync2_val);
			end else begin
				// header cut short, whatever follows is parsed as frame body
				send_byte(sync1_val);
				send_byte(sync2_val);
				send_byte(8'($urandom_range(255)));
			end
		end
		back_to_hunt();
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_sync_hunt();
		send_byte(8'h00);
		send_byte(sync1_val);
		send_byte(8'hFF);
		// second sync seen as a wrong second byte, then not hunted again
		send_byte(sync1_val);
		send_byte(sync1_val);
		send_byte(sync2_val);
		back_to_hunt();
	endtask

	task automatic test_good_frames();
		logic [7:0] pl [$];
		pl.delete();
		send_frame(8'hFF, pl, 1'b0, -1);
		pl.push_back(8'h00);
		pl.push_back(8'hFF);
		send_frame(8'h00, pl, 1'b0, -1);
		back_to_hunt();
	endtask

	task automatic test_bad_crc();
		logic [7:0] pl [$];
		pl.delete();
		pl.push_back(8'h3C);
		send_frame(8'h5A, pl, 1'b1, -1);
		back_to_hunt();
	endtask

	task automatic test_oversize_reject();
		logic [7:0] pl [$];
		pl.delete();
		repeat (255) pl.push_back(8'($urandom_range(255)));
		send_frame(8'hC3, pl, 1'b0, 6);
		back_to_hunt();
	endtask

	// capacity goes up between payload and crc: the tail comes from the store
	// contents left by the earlier two-byte frame
	task automatic test_capacity_raise();
		logic [7:0]  p0;
		logic [7:0]  p1;
		logic [15:0] crc;
		set_config(sync1_val, sync2_val, 8'd1, 8'd0);
		p0  = 8'($urandom_range(255));
		p1  = 8'($urandom_range(255));
		crc = crc_step(crc_step(crc_step(crc_step(CRC_INIT, 8'h11), 8'd2), p0), p1);
		send_byte(sync1_val);
		send_byte(sync2_val);
		send_byte(8'h11);
		send_byte(8'd2);
		send_byte(p0);
		send_byte(p1);
		wait_idle();
		cfg_write(CFG_MAX_PAYLOAD, 8'd2);
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
		back_to_hunt();
	endtask

	task automatic test_traffic_no_idle();
		logic [7:0] pl [$];
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		set_config(8'h00, 8'hFF, 8'd64, 8'd1);
		pl.delete();
		repeat (BUF_DEPTH_DEF) pl.push_back(8'($urandom_range(255)));
		send_frame(8'($urandom_range(255)), pl, 1'b0, -1);
		random_traffic(5);
	endtask

	task automatic test_traffic_sender_idle();
		snd_idle_pct  = 48;
		rcv_stall_pct = 0;
		set_config(8'hFF, 8'h00, 8'd5, 8'd0);
		random_traffic(5);
	endtask

	task automatic test_traffic_receiver_stall();
		snd_idle_pct  = 0;
		rcv_stall_pct = 48;
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0, 8'd0);
		random_traffic(5);
	endtask

	task automatic test_traffic_both_idle();
		snd_idle_pct  = 37;
		rcv_stall_pct = 37;
		set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'd20, 8'd1);
		random_traffic(5);
	endtask

	initial begin : main_seq
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data  <= 8'h00;
		in_valid  <= 1'b0;
		rx_byte   <= 8'h00;
		out_ready <= 1'b0;
		sync1_val = SYNC_FIRST_RST;
		sync2_val = SYNC_SECOND_RST;
		max_pay   = MAX_PAYLOAD_RST;
		rej_over  = REJECT_OVERSIZE_RST;
		restart_hunt();
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sync_hunt();
		test_good_frames();
		test_bad_crc();
		test_oversize_reject();
		test_capacity_raise();
		test_traffic_no_idle();
		test_traffic_sender_idle();
		test_traffic_receiver_stall();
		test_traffic_both_idle();
		wait_idle();

		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* frame_receiver_crc16_check.f */
src/frc_pkg.sv
src/frc_ctrl.sv
src/frc_dp.sv
src/frame_receiver_crc16_check.sv
dv/tb.sv
